// ===== rtl/core/s1md_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 digest block.
`default_nettype none
package s1md_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [3:0] LAST_WORD  = 4'd15;
  localparam logic [3:0] LEN_HI_WORD = 4'd14;

  // Word passed from the byte packer to the compression engine.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  nbytes;  // residual byte count, end-of-message words only
    logic        is_end;
  } cmd_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hEFCD_AB89;
      3'd2:    v = 32'h98BA_DCFE;
      3'd3:    v = 32'h1032_5476;
      3'd4:    v = 32'hC3D2_E1F0;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    case (rnd) inside
      [7'd0:7'd19]:  k = 32'h5A82_7999;
      [7'd20:7'd39]: k = 32'h6ED9_EBA1;
      [7'd40:7'd59]: k = 32'h8F1B_BCDC;
      default:       k = 32'hCA62_C1D6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/s1md_if.sv =====
// Valid/ready stream interfaces for message words and digest words.
`default_nettype none
interface s1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        message_end;

  modport source (output valid, output data_word, output valid_bytes,
                  output message_end, input ready);
  modport sink (input valid, input data_word, input valid_bytes,
                input message_end, output ready);
endinterface

interface s1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/s1md_front.sv =====
// Byte packer: gathers 0 to 4 bytes per word into whole 32-bit words.
`default_nettype none
module s1md_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [31:0]     data_word_i,
  input  wire logic [2:0]      valid_bytes_i,
  input  wire logic            message_end_i,
  output logic                 push_o,
  output s1md_pkg::cmd_t       cmd_o,
  input  wire logic            full_i
);

  logic [23:0] acc_q, acc_d;
  logic [1:0]  acc_n_q, acc_n_d;
  logic        pend_q, pend_d;

  logic [2:0]  cnt_sat;
  logic [31:0] data_masked;
  logic [55:0] cat;
  logic [2:0]  total;
  logic        fire;

  always_comb begin
    cnt_sat     = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    data_masked = data_word_i & ~(32'hFFFF_FFFF >> {cnt_sat, 3'b000});
    cat         = {acc_q, 32'd0} | ({data_masked, 24'd0} >> {acc_n_q, 3'b000});
    total       = {1'b0, acc_n_q} + cnt_sat;
    in_ready_o  = !full_i && !pend_q;
    fire        = in_valid_i && in_ready_o;
  end

  always_comb begin
    acc_d   = acc_q;
    acc_n_d = acc_n_q;
    pend_d  = pend_q;
    push_o  = 1'b0;
    cmd_o   = '{word: cat[55:24], nbytes: 2'd0, is_end: 1'b0};
    if (pend_q) begin
      // flush the residual bytes of a message whose end spilled a whole word
      if (!full_i) begin
        push_o  = 1'b1;
        cmd_o   = '{word: {acc_q, 8'd0}, nbytes: acc_n_q, is_end: 1'b1};
        pend_d  = 1'b0;
        acc_d   = '0;
        acc_n_d = '0;
      end
    end else if (fire) begin
      if (total >= 3'd4) begin
        push_o  = 1'b1;
        acc_d   = cat[23:0];
        acc_n_d = total[1:0];
        pend_d  = message_end_i;
      end else if (message_end_i) begin
        push_o  = 1'b1;
        cmd_o   = '{word: {cat[55:32], 8'd0}, nbytes: total[1:0], is_end: 1'b1};
        acc_d   = '0;
        acc_n_d = '0;
      end else begin
        acc_d   = cat[55:32];
        acc_n_d = total[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      acc_n_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      acc_n_q <= acc_n_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/s1md_queue.sv =====
// Small word queue between the byte packer and the compression engine.
`default_nettype none
module s1md_queue #(
  parameter int unsigned Depth = s1md_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  s1md_pkg::cmd_t       cmd_i,
  output logic                 full_o,
  output logic                 valid_o,
  output s1md_pkg::cmd_t       cmd_o,
  input  wire logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  s1md_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/s1md_back.sv =====
// Compression engine: block loading, padding, 80 rounds and digest output.
`default_nettype none
module s1md_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  s1md_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [31:0]          digest_word_o,
  output logic                 digest_last_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;  // ordinary full block
  localparam logic [1:0] KIND_MORE = 2'd1;  // padding spills into another block
  localparam logic [1:0] KIND_LAST = 2'd2;  // block carrying the bit length

  logic [2:0]        state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [3:0]        wcnt_q, wcnt_d;
  logic [6:0]        round_q, round_d;
  logic [60:0]       bytes_q, bytes_d;
  logic [2:0]        oidx_q, oidx_d;
  logic [4:0][31:0]  chain_q, chain_d;
  logic [4:0][31:0]  work_q, work_d;
  logic [15:0][31:0] sched_q, sched_d;

  logic [31:0] mix, sched_next, pad_word, len_word, t_sum;
  logic [63:0] len_bits;

  always_comb begin
    mix        = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    sched_next = {mix[30:0], mix[31]};
    pad_word   = cmd_i.word | (32'h8000_0000 >> {cmd_i.nbytes, 3'b000});
    len_bits   = {bytes_q, 3'b000};
    if (wcnt_q == s1md_pkg::LEN_HI_WORD) begin
      len_word = len_bits[63:32];
    end else if (wcnt_q == s1md_pkg::LAST_WORD) begin
      len_word = len_bits[31:0];
    end else begin
      len_word = 32'd0;
    end
    t_sum = {work_q[0][26:0], work_q[0][31:27]}
          + s1md_pkg::round_f(round_q, work_q[1], work_q[2], work_q[3])
          + work_q[4] + sched_q[0] + s1md_pkg::round_k(round_q);
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    wcnt_d  = wcnt_q;
    round_d = round_q;
    bytes_d = bytes_q;
    oidx_d  = oidx_q;
    chain_d = chain_q;
    work_d  = work_q;
    sched_d = sched_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o  = 1'b1;
          wcnt_d = wcnt_q + 1'b1;
          if (cmd_i.is_end) begin
            sched_d = {pad_word, sched_q[15:1]};
            bytes_d = bytes_q + 61'(cmd_i.nbytes);
          end else begin
            sched_d = {cmd_i.word, sched_q[15:1]};
            bytes_d = bytes_q + 61'd4;
          end
          if (wcnt_q == s1md_pkg::LAST_WORD) begin
            state_d = ST_ROUND;
            kind_d  = cmd_i.is_end ? KIND_MORE : KIND_DATA;
            round_d = '0;
            work_d  = chain_q;
          end else if (cmd_i.is_end) begin
            state_d = ST_PAD;
            // if there is no room for the length behind this word, zero the block out first
            kind_d  = (wcnt_q == s1md_pkg::LEN_HI_WORD) ? KIND_MORE : KIND_LAST;
          end
        end
      end
      ST_PAD: begin
        // zero fill; in the last block, the bit length goes in the last two words
        sched_d = {(kind_q == KIND_LAST) ? len_word : 32'd0, sched_q[15:1]};
        wcnt_d  = wcnt_q + 1'b1;
        if (wcnt_q == s1md_pkg::LAST_WORD) begin
          state_d = ST_ROUND;
          round_d = '0;
          work_d  = chain_q;
        end
      end
      ST_ROUND: begin
        work_d  = {work_q[3], work_q[2], {work_q[1][1:0], work_q[1][31:2]},
                   work_q[0], t_sum};
        sched_d = {sched_next, sched_q[15:1]};
        round_d = round_q + 1'b1;
        if (round_q == s1md_pkg::LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        case (kind_q)
          KIND_MORE: begin
            state_d = ST_PAD;
            kind_d  = KIND_LAST;
          end
          KIND_LAST: begin
            state_d = ST_OUT;
            oidx_d  = '0;
            bytes_d = '0;
          end
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_ready_i) begin
          // shift the digest out and refill with the initial values behind it
          chain_d = {s1md_pkg::iv_word(oidx_q), chain_q[4:1]};
          oidx_d  = oidx_q + 1'b1;
          if (oidx_q == 3'd4) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[0];
  assign digest_last_o = (oidx_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_DATA;
      wcnt_q  <= '0;
      round_q <= '0;
      bytes_q <= '0;
      oidx_q  <= '0;
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= s1md_pkg::iv_word(3'(i));
      end
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      wcnt_q  <= wcnt_d;
      round_q <= round_d;
      bytes_q <= bytes_d;
      oidx_q  <= oidx_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    sched_q <= sched_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha1_message_digest.sv =====
// Top level of the SHA-1 message digest block.
//
//   channel   dir   word carries                                   accepted when
//   data_i    in    data_word, valid_bytes, message_end            valid && ready
//   digest_o  out   digest_word, digest_last (H0 first, H4 last)   valid && ready
//
// Each 64-byte block costs 16 word loads, 80 rounds and one chaining add, with
// the single round unit doing one round per cycle. Message end adds padding,
// possibly one extra block, then five digest words. The packer and engine are
// split by a word queue, so input flows on while the engine runs or the digest
// waits, until the queue fills. Reset is asynchronous and leaves the engine idle
// with the initial chaining values loaded.
`default_nettype none
module sha1_message_digest #(
  parameter int unsigned QueueDepth = s1md_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  s1md_in_if.sink    data_i,
  s1md_out_if.source digest_o
);

  logic           push, full, cmd_valid, pop;
  s1md_pkg::cmd_t push_cmd, pop_cmd;

  s1md_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (data_i.valid),
    .in_ready_o    (data_i.ready),
    .data_word_i   (data_i.data_word),
    .valid_bytes_i (data_i.valid_bytes),
    .message_end_i (data_i.message_end),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  s1md_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (pop_cmd),
    .pop_i   (pop)
  );

  s1md_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (digest_o.valid),
    .out_ready_i   (digest_o.ready),
    .digest_word_o (digest_o.digest_word),
    .digest_last_o (digest_o.digest_last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/s1md_checker.sv =====
// Port-level checks on the digest output sequence, bound to the top level.
`default_nettype none
module s1md_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] digest_word_i,
  input wire logic        digest_last_i
);

  // a stalled digest word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digest_word_i)
                                    && $stable(digest_last_i))
    else $error("digest word changed while stalled");

  // words of one digest follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !digest_last_i |=> out_valid_i)
    else $error("digest sequence broke off before the last word");

  // a new digest needs a full compression, so none follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && digest_last_i |=> !out_valid_i)
    else $error("digest word offered straight after the last one");

  // the last flag never appears twice in a row on taken words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && digest_last_i |=> !digest_last_i)
    else $error("last flag repeated");

endmodule

bind sha1_message_digest s1md_props u_s1md_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (digest_o.valid),
  .out_ready_i   (digest_o.ready),
  .digest_word_i (digest_o.digest_word),
  .digest_last_i (digest_o.digest_last)
);
`default_nettype wire
